/* hw/rtl/hcp_pkg.sv */
// Shared types, constants and helper functions for the Connection header parser.
// No dependencies; imported by the token tracker, the result register and the top level.
package hcp_pkg;

	localparam int NUM_WORDS = 3;
	localparam int TXT_W     = 80;
	localparam int CNT_W     = 4;

	// Bit positions in the seen / candidate masks
	localparam int IDX_CLOSE   = 0;
	localparam int IDX_KEEP    = 1;
	localparam int IDX_UPGRADE = 2;

	localparam logic [NUM_WORDS-1:0] BIT_CLOSE   = 3'b001;
	localparam logic [NUM_WORDS-1:0] BIT_KEEP    = 3'b010;
	localparam logic [NUM_WORDS-1:0] BIT_UPGRADE = 3'b100;

	// Item kinds carried in tuser
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CASE  = 8'h20;

	// Token texts, right-aligned, first character in the highest used byte
	localparam logic [TXT_W-1:0] WORD_TXT [NUM_WORDS] = '{
		TXT_W'("close"),
		TXT_W'("keep-alive"),
		TXT_W'("upgrade")
	};
	localparam logic [CNT_W-1:0] WORD_LEN [NUM_WORDS] = '{4'd5, 4'd10, 4'd7};

	typedef struct packed {
		logic       req_type;
		logic [7:0] header_byte;
		logic       is_http_1_0;
	} hcp_item_t;

	typedef struct packed {
		logic should_close;
		logic header_error;
		logic upgrade_seen;
		logic keep_alive_seen;
		logic close_seen;
	} hcp_result_t;

	// Character idx of a token text; only meaningful for idx < len
	function automatic logic [7:0] word_byte(input logic [TXT_W-1:0] txt,
			input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] idx);
		logic [CNT_W-1:0] pos;
		pos = len - idx - 4'd1;
		return txt[{pos, 3'b000} +: 8];
	endfunction

endpackage

/* hw/rtl/hcp_token_fsm.sv */
// Token tracker: phase, count, candidates, seen mask and sticky error, updated once
// per header item. Depends on hcp_pkg.
module hcp_token_fsm
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  hcp_item_t   item,
	output hcp_result_t result
);

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_TOKEN = 2'd1,
		PH_TRAIL = 2'd2
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [NUM_WORDS-1:0]   cand_q, cand_d;
	logic [NUM_WORDS-1:0]   seen_q, seen_d;
	logic                   err_q, err_d;
	logic                   bsc_q, bsc_d;

	logic [NUM_WORDS-1:0]   hit;
	logic [NUM_WORDS-1:0]   fin_seen, end_seen;
	logic                   fin_err, end_err;
	logic [7:0]             ch;
	logic                   blank;

	// Closing a token: which word (if any) it completed
	always_comb begin
		hit = '0;
		if (phase_q != PH_LEAD) begin
			for (int k = 0; k < NUM_WORDS; k++) begin
				hit[k] = cand_q[k] && (cnt_q == WORD_LEN[k]);
			end
		end
		fin_err  = err_q;
		fin_seen = seen_q;
		if (hit == '0) begin
			fin_err = 1'b1;
		end else if ((hit == BIT_CLOSE && seen_q[IDX_KEEP]) ||
				(hit == BIT_KEEP && seen_q[IDX_CLOSE])) begin
			fin_err = 1'b1;
		end else begin
			fin_seen = seen_q | hit;
		end
	end

	always_comb begin
		ch = item.header_byte;
		if (item.header_byte inside {[8'h41:8'h5A]}) begin
			ch = item.header_byte + CH_CASE;
		end
		blank = (item.header_byte == CH_SPACE) || (item.header_byte == CH_TAB);

		phase_d = phase_q;
		cnt_d   = cnt_q;
		cand_d  = cand_q;
		seen_d  = seen_q;
		err_d   = err_q;
		bsc_d   = bsc_q;

		end_err  = err_q;
		end_seen = seen_q;
		if (!err_q && bsc_q) begin
			end_err  = fin_err;
			end_seen = fin_seen;
		end

		if (item.req_type == REQ_END) begin
			// back to the idle state for the next header
			phase_d = PH_LEAD;
			cnt_d   = '0;
			cand_d  = '1;
			seen_d  = '0;
			err_d   = 1'b0;
			bsc_d   = 1'b0;
		end else if (!err_q) begin
			if (item.header_byte == CH_COMMA) begin
				err_d   = fin_err;
				seen_d  = fin_seen;
				phase_d = PH_LEAD;
				cnt_d   = '0;
				cand_d  = '1;
				bsc_d   = 1'b0;
			end else begin
				bsc_d = 1'b1;
				if (blank) begin
					if (phase_q != PH_LEAD) begin
						phase_d = PH_TRAIL;
					end
				end else if (phase_q == PH_TRAIL) begin
					// inner blank kills the token
					cand_d = '0;
				end else begin
					phase_d = PH_TOKEN;
					for (int k = 0; k < NUM_WORDS; k++) begin
						if (cand_q[k] && ((cnt_q >= WORD_LEN[k]) ||
								(word_byte(WORD_TXT[k], WORD_LEN[k], cnt_q) != ch))) begin
							cand_d[k] = 1'b0;
						end
					end
					if (cnt_q != '1) begin
						cnt_d = cnt_q + 4'd1;
					end
				end
			end
		end

		result.close_seen      = end_seen[IDX_CLOSE];
		result.keep_alive_seen = end_seen[IDX_KEEP];
		result.upgrade_seen    = end_seen[IDX_UPGRADE];
		result.header_error    = end_err;
		if (end_err) begin
			result.should_close = 1'b1;
		end else if (end_seen == '0) begin
			result.should_close = item.is_http_1_0;
		end else begin
			result.should_close = end_seen[IDX_CLOSE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			cnt_q   <= '0;
			cand_q  <= '1;
			seen_q  <= '0;
			err_q   <= 1'b0;
			bsc_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			cand_q  <= cand_d;
			seen_q  <= seen_d;
			err_q   <= err_d;
			bsc_q   <= bsc_d;
		end
	end

endmodule

/* hw/rtl/hcp_out_reg.sv */
// Result register for the master-side stream; frees itself on the same cycle it
// is taken. Depends on hcp_pkg.
module hcp_out_reg
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  hcp_result_t result,
	input  logic        m_axis_tready,
	output logic        m_axis_tvalid,
	output logic [7:0]  m_axis_tdata,
	output logic        can_load
);

	logic        valid_q;
	hcp_result_t data_q;

	assign can_load      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {3'b000, data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= result;
		end
	end

endmodule

/* hw/rtl/http_connection_header_parser.sv */
// Top level of the HTTP Connection header token parser: input register, token
// tracker and result register. Depends on hcp_pkg, hcp_token_fsm, hcp_out_reg.
//
//  channel   dir  bus            fields (lowest bit first)
//  s_axis    in   tdata[15:0]    header_byte[7:0], is_http_1_0[8], zero pad
//                 tuser[0]       req_type (0 = value byte, 1 = end of value)
//  m_axis    out  tdata[7:0]     close_seen, keep_alive_seen, upgrade_seen,
//                                header_error, should_close, zero pad
//
// One item per cycle. An accepted item is held in the input register, where the
// tracker updates its state; an end item then loads the result register once that
// register has room, and m_axis_tvalid rises when it is loaded. Byte items never
// produce a transfer on m_axis. Only an end item can stall, when the result
// register is full and not being taken; s_axis_tready then drops. arst_n clears
// all control state; the tracker restarts at the first byte.
module http_connection_header_parser
	import hcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // header_byte, is_http_1_0, pad
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // close, keep-alive, upgrade, error, should_close, pad
);

	logic        valid_s1;
	hcp_item_t   item_s1;
	logic        can_load;
	logic        adv_s1;
	hcp_result_t result;

	// Byte items always move on; an end item waits for room in the result register
	assign adv_s1        = valid_s1 && ((item_s1.req_type == REQ_BYTE) || can_load);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.req_type    <= s_axis_tuser;
			item_s1.header_byte <= s_axis_tdata[7:0];
			item_s1.is_http_1_0 <= s_axis_tdata[8];
		end
	end

	hcp_token_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.item   (item_s1),
		.result (result)
	);

	hcp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv_s1 && (item_s1.req_type == REQ_END)),
		.result        (result),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.can_load      (can_load)
	);

endmodule

/* hw/rtl/hcp_checker.sv */
// Port-level checks for the Connection header parser, bound to the top level.
// Depends on http_connection_header_parser port names only.
module hcp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
		else $error("result pad bits not zero");

	a_err_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[4])
		else $error("error without close decision");

	a_no_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
		else $error("close and keep-alive both reported");

	// No end transfer and an empty output after it: the output then stays empty
	a_byte_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tvalid && s_axis_tready && s_axis_tuser) ##1 !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result without end item");

endmodule

bind http_connection_header_parser hcp_checker u_hcp_checker (.*);
